// ----- rtl/utf8_validity_splitter_core_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-8 validity splitter assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDITY_SPLITTER_CORE_ASSERT_SVH
`define UTF8_VALIDITY_SPLITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define U8VS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8vs assertion failed");

// Next-cycle implication, disabled during reset.
`define U8VS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8vs assertion failed");

`else

`define U8VS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define U8VS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/u8vs_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 validity splitter package
// Decoder state encoding, per-byte step result and byte class functions.
// ----------------------------------------------------------------------------
`default_nettype none

package u8vs_pkg;

    // What the decoder expects from the next byte.
    typedef enum logic [2:0] {
        KIND_START = 3'd0,  // a new character
        KIND_CONT1 = 3'd1,  // one more continuation byte 80..BF
        KIND_CONT2 = 3'd2,  // two more, next 80..BF
        KIND_E0    = 3'd3,  // after E0, next A0..BF
        KIND_ED    = 3'd4,  // after ED, next 80..9F
        KIND_CONT3 = 3'd5,  // three more, next 80..BF
        KIND_F0    = 3'd6,  // after F0, next 90..BF
        KIND_F4    = 3'd7   // after F4, next 80..8F
    } kind_t;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] E0_LO       = 8'hA0;
    localparam logic [7:0] ED_HI       = 8'h9F;
    localparam logic [7:0] F0_LO       = 8'h90;
    localparam logic [7:0] F4_HI       = 8'h8F;

    // Outcome of one byte: next decoder state and counter increments.
    typedef struct packed {
        kind_t      kind;
        logic [1:0] pend;
        logic       in_run;
        logic       valid_inc;
        logic [2:0] bad_add;
        logic       run_inc;
    } step_t;

    // Lowest continuation byte accepted in a given state.
    function automatic logic [7:0] cont_lo(input kind_t kind);
        unique case (kind)
            KIND_E0: return E0_LO;
            KIND_F0: return F0_LO;
            default: return CONT_LO;
        endcase
    endfunction

    // Highest continuation byte accepted in a given state.
    function automatic logic [7:0] cont_hi(input kind_t kind);
        unique case (kind)
            KIND_ED: return ED_HI;
            KIND_F4: return F4_HI;
            default: return CONT_HI;
        endcase
    endfunction

    // State after a continuation byte has been taken.
    function automatic kind_t next_kind(input kind_t kind);
        unique case (kind) inside
            KIND_CONT2, KIND_E0, KIND_ED:    return KIND_CONT1;
            KIND_CONT3, KIND_F0, KIND_F4:    return KIND_CONT2;
            default:                         return KIND_START;
        endcase
    endfunction

    // State opened by a lead byte; KIND_START marks a byte that cannot lead.
    function automatic kind_t lead_kind(input logic [7:0] b);
        unique case (b) inside
            [8'hC2:8'hDF]: return KIND_CONT1;
            8'hE0:         return KIND_E0;
            8'hED:         return KIND_ED;
            [8'hE1:8'hEC],
            [8'hEE:8'hEF]: return KIND_CONT2;
            8'hF0:         return KIND_F0;
            [8'hF1:8'hF3]: return KIND_CONT3;
            8'hF4:         return KIND_F4;
            default:       return KIND_START;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/u8vs_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 validity splitter channels
// Valid/ready channels for the byte stream and for the count results.
// ----------------------------------------------------------------------------
`default_nettype none

// Byte stream: one byte per transfer with a last-byte flag.
interface u8vs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result: the three counts for one buffer.
interface u8vs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] multibyte_count;
    logic [31:0] foreign_count;
    logic [31:0] run_count;

    modport source (output valid, output multibyte_count, output foreign_count,
                    output run_count, input ready);
    modport sink   (input valid, input multibyte_count, input foreign_count,
                    input run_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/u8vs_step.sv -----
// ----------------------------------------------------------------------------
// UTF-8 validity splitter byte step
// Next decoder state and counter increments for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8vs_step (
    input  var u8vs_pkg::kind_t kind,
    input  wire logic [1:0]     pend,
    input  wire logic           in_run,
    input  wire logic [7:0]     data_byte,
    input  wire logic           last_byte,
    output u8vs_pkg::step_t     step
);

    // Walk the byte through the open sequence, a fresh start and the end check.
    always_comb
    begin
        u8vs_pkg::kind_t k;
        u8vs_pkg::kind_t lk;
        logic [1:0]      p;
        logic            r;
        logic            vinc;
        logic [2:0]      bad;
        logic            rinc;
        logic            fresh;

        k     = kind;
        p     = pend;
        r     = in_run;
        vinc  = 1'b0;
        bad   = 3'd0;
        rinc  = 1'b0;
        fresh = 1'b1;
        lk    = u8vs_pkg::KIND_START;

        // An open sequence either takes the byte or breaks.
        if (kind != u8vs_pkg::KIND_START)
        begin
            if (data_byte >= u8vs_pkg::cont_lo(kind) &&
                data_byte <= u8vs_pkg::cont_hi(kind))
            begin
                fresh = 1'b0;
                p     = pend + 2'd1;
                k     = u8vs_pkg::next_kind(kind);
                if (k == u8vs_pkg::KIND_START)
                begin
                    vinc = 1'b1;
                    r    = 1'b0;
                    p    = 2'd0;
                end
            end
            else
            begin
                // The bytes taken so far become foreign.
                if (pend != 2'd0)
                begin
                    bad = {1'b0, pend};
                    if (!r)
                    begin
                        rinc = 1'b1;
                    end
                    r = 1'b1;
                end
                k = u8vs_pkg::KIND_START;
                p = 2'd0;
            end
        end

        // The byte starts a new character.
        if (fresh)
        begin
            if (data_byte < u8vs_pkg::ASCII_LIMIT)
            begin
                r = 1'b0;
            end
            else
            begin
                lk = u8vs_pkg::lead_kind(data_byte);
                if (lk != u8vs_pkg::KIND_START)
                begin
                    k = lk;
                    p = 2'd1;
                end
                else
                begin
                    bad = bad + 3'd1;
                    if (!r)
                    begin
                        rinc = 1'b1;
                    end
                    r = 1'b1;
                end
            end
        end

        // At the end of the buffer a truncated sequence is foreign.
        if (last_byte)
        begin
            if (p != 2'd0)
            begin
                bad = bad + {1'b0, p};
                if (!r)
                begin
                    rinc = 1'b1;
                end
            end
            k = u8vs_pkg::KIND_START;
            p = 2'd0;
            r = 1'b0;
        end

        step.kind      = k;
        step.pend      = p;
        step.in_run    = r;
        step.valid_inc = vinc;
        step.bad_add   = bad;
        step.run_inc   = rinc;
    end

endmodule

`default_nettype wire

// ----- rtl/utf8_validity_splitter_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 validity splitter core
// Streaming UTF-8 well-formedness checker with saturating counters.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle on the stream channel, except while
// a last byte waits, and reports on the byte flagged as last one result with
// the count of valid 2 to 4 byte sequences, of foreign bytes and of runs of
// foreign bytes, after which it starts the next buffer from a clean state. A
// byte passes through an input register and is decided from there by the
// per-byte step logic and the counter incrementers; the result register is
// loaded when the last byte of a buffer is decided. The last byte of a buffer
// waits in the input register only while the previous result is still held
// in the result register and not taken; other bytes never wait. Counters are
// COUNT_WIDTH bits wide and saturate; the 32-bit result fields saturate as well.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_validity_splitter_core_assert.svh"

module utf8_validity_splitter_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    u8vs_in_if.sink     stream,
    u8vs_out_if.source  result
);

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Decoder state and counters.
    u8vs_pkg::kind_t        kind_reg;
    logic [1:0]             pend_reg;
    logic                   in_run_reg;
    logic [COUNT_WIDTH-1:0] valid_cnt_reg;
    logic [COUNT_WIDTH-1:0] bad_cnt_reg;
    logic [COUNT_WIDTH-1:0] run_cnt_reg;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] multibyte_reg;
    logic [31:0] foreign_reg;
    logic [31:0] runs_reg;

    u8vs_pkg::step_t        step;
    logic                   out_free;
    logic                   s1_fire;
    logic [COUNT_WIDTH:0]   valid_sum;
    logic [COUNT_WIDTH:0]   bad_sum;
    logic [COUNT_WIDTH:0]   run_sum;
    logic [COUNT_WIDTH-1:0] valid_next;
    logic [COUNT_WIDTH-1:0] bad_next;
    logic [COUNT_WIDTH-1:0] run_next;

    // Saturate a counter value to a 32-bit result field.
    function automatic logic [31:0] clamp32(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+31:0] ext;
        ext = {32'd0, v};
        return (|ext[COUNT_WIDTH+31:32]) ? 32'hFFFF_FFFF : ext[31:0];
    endfunction

    u8vs_step u_step (
        .kind      (kind_reg),
        .pend      (pend_reg),
        .in_run    (in_run_reg),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .step      (step)
    );

    // Flow control: only a last byte needs room in the result register.
    assign out_free     = !out_valid_reg || result.ready;
    assign s1_fire      = s1_valid_reg && (!s1_last_reg || out_free);
    assign stream.ready = !s1_valid_reg || s1_fire;

    // Saturating counter updates.
    assign valid_sum  = {1'b0, valid_cnt_reg}
                      + {{COUNT_WIDTH{1'b0}}, step.valid_inc};
    assign bad_sum    = {1'b0, bad_cnt_reg}
                      + {{(COUNT_WIDTH-2){1'b0}}, step.bad_add};
    assign run_sum    = {1'b0, run_cnt_reg}
                      + {{COUNT_WIDTH{1'b0}}, step.run_inc};
    assign valid_next = valid_sum[COUNT_WIDTH] ? '1 : valid_sum[COUNT_WIDTH-1:0];
    assign bad_next   = bad_sum[COUNT_WIDTH]   ? '1 : bad_sum[COUNT_WIDTH-1:0];
    assign run_next   = run_sum[COUNT_WIDTH]   ? '1 : run_sum[COUNT_WIDTH-1:0];

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s1_byte_reg <= stream.data_byte;
            s1_last_reg <= stream.last_byte;
        end
    end

    // Decoder state and counters; a last byte returns them to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= u8vs_pkg::KIND_START;
            pend_reg      <= 2'd0;
            in_run_reg    <= 1'b0;
            valid_cnt_reg <= '0;
            bad_cnt_reg   <= '0;
            run_cnt_reg   <= '0;
        end
        else if (s1_fire)
        begin
            kind_reg   <= step.kind;
            pend_reg   <= step.pend;
            in_run_reg <= step.in_run;
            if (s1_last_reg)
            begin
                valid_cnt_reg <= '0;
                bad_cnt_reg   <= '0;
                run_cnt_reg   <= '0;
            end
            else
            begin
                valid_cnt_reg <= valid_next;
                bad_cnt_reg   <= bad_next;
                run_cnt_reg   <= run_next;
            end
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            multibyte_reg <= clamp32(valid_next);
            foreign_reg   <= clamp32(bad_next);
            runs_reg      <= clamp32(run_next);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.multibyte_count = multibyte_reg;
    assign result.foreign_count   = foreign_reg;
    assign result.run_count       = runs_reg;

    // No bytes are pending exactly when a new character is expected.
    `U8VS_ASSERT_NOW(a_pend_matches_kind, clk, rst_n, 1'b1,
        (kind_reg == u8vs_pkg::KIND_START) == (pend_reg == 2'd0))

    // A decided last byte leaves a clean decoder behind.
    `U8VS_ASSERT_NEXT(a_last_clears, clk, rst_n, s1_fire && s1_last_reg,
        kind_reg == u8vs_pkg::KIND_START && !in_run_reg && valid_cnt_reg == '0
        && bad_cnt_reg == '0 && run_cnt_reg == '0)

    // A result only appears after a last byte was decided.
    `U8VS_ASSERT_NOW(a_result_from_last, clk, rst_n, $rose(out_valid_reg),
        $past(s1_fire && s1_last_reg))

    // A last byte that finds the result register busy waits in place.
    `U8VS_ASSERT_NEXT(a_last_waits, clk, rst_n, s1_valid_reg && s1_last_reg && !out_free,
        s1_valid_reg && s1_last_reg && $stable(s1_byte_reg))

endmodule

`default_nettype wire

// ----- sim/utf8_splitter_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 validity splitter checker
// Watches the byte and result channels, predicts the counts per buffer and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_splitter_checker (
    input  logic       clk,
    input  logic       rst_n,
    u8vs_in_if         stream,
    u8vs_out_if        result,
    output int         errors,
    output int         pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] tally_t;

    typedef struct {
        logic [31:0] multibyte;
        logic [31:0] foreign;
        logic [31:0] runs;
    } buffer_counts_t;

    // Decoder state kept alongside the block.
    u8vs_pkg::kind_t dec_kind;
    logic [1:0]      dec_pend;
    logic            dec_in_run;
    tally_t          multibyte_tally;
    tally_t          foreign_tally;
    tally_t          run_tally;

    buffer_counts_t expected_counts[$];

    // Saturating counter increment.
    function automatic tally_t sat_bump(input tally_t a, input logic [2:0] n);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, a} + {{(COUNT_WIDTH-2){1'b0}}, n};
        return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    endfunction

    // Result fields are 32 bits wide and saturate on their own.
    function automatic logic [31:0] to_field(input tally_t c);
        return (c > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(c);
    endfunction

    function automatic void clear_decoder();
        dec_kind        = u8vs_pkg::KIND_START;
        dec_pend        = '0;
        dec_in_run      = 1'b0;
        multibyte_tally = '0;
        foreign_tally   = '0;
        run_tally       = '0;
    endfunction

    // Counts n foreign bytes and opens a run if none is open.
    function automatic void tally_foreign(input logic [2:0] n);
        if (n != 0)
        begin
            foreign_tally = sat_bump(foreign_tally, n);
            if (!dec_in_run)
            begin
                run_tally  = sat_bump(run_tally, 3'd1);
                dec_in_run = 1'b1;
            end
        end
    endfunction

    // Examines a byte as the start of a new character.
    function automatic void open_char(input logic [7:0] b);
        u8vs_pkg::kind_t k;
        k = u8vs_pkg::KIND_START;
        if (b < u8vs_pkg::ASCII_LIMIT)
        begin
            dec_in_run = 1'b0;
            return;
        end
        if (b >= 8'hC2 && b <= 8'hDF)
            k = u8vs_pkg::KIND_CONT1;
        else if (b == 8'hE0)
            k = u8vs_pkg::KIND_E0;
        else if (b == 8'hED)
            k = u8vs_pkg::KIND_ED;
        else if (b >= 8'hE1 && b <= 8'hEF)
            k = u8vs_pkg::KIND_CONT2;
        else if (b == 8'hF0)
            k = u8vs_pkg::KIND_F0;
        else if (b >= 8'hF1 && b <= 8'hF3)
            k = u8vs_pkg::KIND_CONT3;
        else if (b == 8'hF4)
            k = u8vs_pkg::KIND_F4;
        if (k == u8vs_pkg::KIND_START)
            tally_foreign(3'd1);
        else
        begin
            dec_kind = k;
            dec_pend = 2'd1;
        end
    endfunction

    // Advances the decoder by one byte; the last byte of a buffer queues
    // the counts that the block must report.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [7:0]     lo;
        logic [7:0]     hi;
        buffer_counts_t counts;
        if (dec_kind != u8vs_pkg::KIND_START)
        begin
            lo = u8vs_pkg::CONT_LO;
            hi = u8vs_pkg::CONT_HI;
            case (dec_kind)
                u8vs_pkg::KIND_E0: lo = u8vs_pkg::E0_LO;
                u8vs_pkg::KIND_F0: lo = u8vs_pkg::F0_LO;
                u8vs_pkg::KIND_ED: hi = u8vs_pkg::ED_HI;
                u8vs_pkg::KIND_F4: hi = u8vs_pkg::F4_HI;
                default: ;
            endcase
            if (b >= lo && b <= hi)
            begin
                dec_pend = dec_pend + 2'd1;
                case (dec_kind) inside
                    u8vs_pkg::KIND_CONT2, u8vs_pkg::KIND_E0, u8vs_pkg::KIND_ED:
                        dec_kind = u8vs_pkg::KIND_CONT1;
                    u8vs_pkg::KIND_CONT3, u8vs_pkg::KIND_F0, u8vs_pkg::KIND_F4:
                        dec_kind = u8vs_pkg::KIND_CONT2;
                    default:
                        dec_kind = u8vs_pkg::KIND_START;
                endcase
                if (dec_kind == u8vs_pkg::KIND_START)
                begin
                    multibyte_tally = sat_bump(multibyte_tally, 3'd1);
                    dec_in_run      = 1'b0;
                    dec_pend        = '0;
                end
            end
            else
            begin
                // Broken sequence: what was taken is foreign, and the byte
                // is looked at again as a new character.
                tally_foreign({1'b0, dec_pend});
                dec_kind = u8vs_pkg::KIND_START;
                dec_pend = '0;
                open_char(b);
            end
        end
        else
            open_char(b);

        if (last)
        begin
            // Bytes of a sequence left open at the end are foreign.
            tally_foreign({1'b0, dec_pend});
            counts.multibyte = to_field(multibyte_tally);
            counts.foreign   = to_field(foreign_tally);
            counts.runs      = to_field(run_tally);
            expected_counts.push_back(counts);
            clear_decoder();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Compare result transfers first, then fold in the byte transfer.
    always @(posedge clk or negedge rst_n)
    begin
        buffer_counts_t want;
        if (!rst_n)
        begin
            clear_decoder();
            expected_counts.delete();
            errors          = 0;
            pending_results <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_counts.size() == 0)
                    report_mismatch("result with no buffer outstanding",
                                    result.foreign_count, 32'd0);
                else
                begin
                    want = expected_counts.pop_front();
                    if (result.multibyte_count !== want.multibyte)
                        report_mismatch("multibyte_count", result.multibyte_count,
                                        want.multibyte);
                    if (result.foreign_count !== want.foreign)
                        report_mismatch("foreign_count", result.foreign_count,
                                        want.foreign);
                    if (result.run_count !== want.runs)
                        report_mismatch("run_count", result.run_count, want.runs);
                end
            end
            if (stream.valid && stream.ready)
                decode_byte(stream.data_byte, stream.last_byte);
            pending_results <= expected_counts.size();
        end
    end

endmodule

// ----- sim/tb_utf8_validity_splitter_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 validity splitter testbench
// Feeds directed and random byte buffers with bursty transfers and a stalling
// result sink; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_utf8_validity_splitter_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES   = 2000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_CHOKE
    } sink_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    u8vs_in_if  stream ();
    u8vs_out_if result ();

    int check_errors;
    int pending_results;

    int         burst_left = 0;
    int         bytes_sent = 0;
    int         idle_cycles = 0;
    int         hold_cnt = 0;
    logic [8:0] mode_timer = '0;
    sink_mode_t sink_mode = SINK_OPEN;
    logic [7:0] buf_q[$];

    utf8_validity_splitter_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result)
    );

    utf8_splitter_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .stream          (stream),
        .result          (result),
        .errors          (check_errors),
        .pending_results (pending_results)
    );

    always #4 clk = ~clk;

    // Offers one byte and holds it until the transfer; bursts of random
    // length are separated by random gaps.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0)
        begin
            stream.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        stream.valid     <= 1'b1;
        stream.data_byte <= b;
        stream.last_byte <= last;
        @(posedge clk);
        while (!stream.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++)
            push_byte(buf_q[i], i == buf_q.size() - 1);
    endtask

    // Appends the first keep bytes of a random well-formed sequence of len bytes.
    function automatic void append_seq(input int len, input int keep);
        logic [7:0] s [0:3];
        s[1] = 8'($urandom_range(8'h80, 8'hBF));
        s[2] = 8'($urandom_range(8'h80, 8'hBF));
        s[3] = 8'($urandom_range(8'h80, 8'hBF));
        if (len == 2)
            s[0] = 8'($urandom_range(8'hC2, 8'hDF));
        else if (len == 3)
        begin
            case ($urandom_range(0, 3))
                0: begin s[0] = 8'hE0; s[1] = 8'($urandom_range(8'hA0, 8'hBF)); end
                1: begin s[0] = 8'hED; s[1] = 8'($urandom_range(8'h80, 8'h9F)); end
                2: s[0] = 8'($urandom_range(8'hE1, 8'hEC));
                default: s[0] = 8'($urandom_range(8'hEE, 8'hEF));
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: begin s[0] = 8'hF0; s[1] = 8'($urandom_range(8'h90, 8'hBF)); end
                1: begin s[0] = 8'hF4; s[1] = 8'($urandom_range(8'h80, 8'h8F)); end
                default: s[0] = 8'($urandom_range(8'hF1, 8'hF3));
            endcase
        end
        for (int i = 0; i < keep; i++)
            buf_q.push_back(s[i]);
    endfunction

    // A buffer is mostly ASCII and whole sequences, with some truncated
    // sequences and raw noise mixed in.
    task automatic send_random_buffer();
        int chunks;
        int pick;
        int len;
        buf_q.delete();
        chunks = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 8);
        repeat (chunks)
        begin
            pick = $urandom_range(0, 19);
            len  = $urandom_range(2, 4);
            if (pick < 6)
                buf_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
            else if (pick < 14)
                append_seq(len, len);
            else if (pick < 17)
                append_seq(len, $urandom_range(1, len - 1));
            else
                buf_q.push_back(8'($urandom_range(8'h00, 8'hFF)));
        end
        send_buffer();
    endtask

    // Result sink: switches, each time the 9-bit mode timer wraps, between always ready,
    // coin-flip ready and long stalls.
    always @(posedge clk)
    begin
        mode_timer <= mode_timer + 9'd1;
        if (mode_timer == '0)
            sink_mode <= sink_mode_t'($urandom_range(0, 2));
        case (sink_mode)
            SINK_OPEN: result.ready <= 1'b1;
            SINK_COIN: result.ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (hold_cnt == 0)
                begin
                    result.ready <= !result.ready;
                    hold_cnt <= result.ready ? $urandom_range(1, 24)
                                             : $urandom_range(0, 3);
                end
                else
                    hold_cnt <= hold_cnt - 1;
            end
        endcase
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((stream.valid && stream.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        stream.valid     = 1'b0;
        stream.data_byte = '0;
        stream.last_byte = 1'b0;
        result.ready     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Bad lead bytes and ASCII extremes.
        buf_q = '{8'h00, 8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hF5, 8'hFF, 8'h7F};
        send_buffer();
        // Two-byte extreme, overlong after E0, surrogate after ED.
        buf_q = '{8'hC2, 8'h80, 8'hE0, 8'h9F, 8'hED, 8'h9F, 8'hBF, 8'hED, 8'hA0};
        send_buffer();
        // Top code point, overlong after F0, truncated at the end.
        buf_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF0, 8'h8F, 8'hF4};
        send_buffer();
        // A lone lead byte as the whole buffer.
        buf_q = '{8'hE1};
        send_buffer();

        while (bytes_sent < RANDOM_BYTES)
            send_random_buffer();
        stream.valid <= 1'b0;

        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (check_errors == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
